FILE: rtl/bertlv_pkg.sv
// shared types and constants of the ber tlv header / integer encoder
`default_nettype none

package bertlv_pkg;

    // input transaction layout
    localparam int CLASS_W     = 3;
    localparam int TAG_W       = 32;
    localparam int CLEN_W      = 32;
    localparam int INT_W       = 64;
    localparam int S_FIELD_W   = CLASS_W + TAG_W + CLEN_W + INT_W;
    localparam int S_TDATA_W   = ((S_FIELD_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = 2;
    localparam int CLASS_LSB   = 0;
    localparam int TAG_LSB     = CLASS_LSB + CLASS_W;
    localparam int CLEN_LSB    = TAG_LSB + TAG_W;
    localparam int INT_LSB     = CLEN_LSB + CLEN_W;
    localparam int TUSER_REQ   = 0;
    localparam int TUSER_WIDE  = 1;

    // output transaction layout
    localparam int M_TDATA_W   = 8;

    // request kinds
    localparam logic REQ_HEADER  = 1'b0;
    localparam logic REQ_INTEGER = 1'b1;

    // encoding constants
    localparam logic [4:0] HIGH_TAG_MARK = 5'h1f;
    localparam logic [7:0] DIGIT_MASK    = 8'h7f;
    localparam logic [7:0] MORE_DIGITS   = 8'h80;
    localparam logic [7:0] LONG_FORM     = 8'h80;
    localparam logic [TAG_W-1:0]  SHORT_TAG_MAX   = 32'd30;
    localparam logic [CLEN_W-1:0] SHORT_LEN_LIMIT = 32'd128;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified request, ready to be serialized
    typedef struct packed {
        logic             err;       // rejected class, single error result
        logic [7:0]       hdr_byte;  // first identifier octet
        logic [2:0]       n_dig;     // base-128 tag digits after the first octet
        logic [TAG_W-1:0] tag;
        logic [7:0]       len_byte;  // short length or long-form count octet
        logic [3:0]       n_body;    // big-endian bytes following the length octet
        logic [INT_W-1:0] body;      // length value or integer content
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/bertlv_front.sv
// front end: classifies an input transaction into a serialization job
`default_nettype none

module bertlv_front (
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: ident_class, tag_number, content_length, int_value, zero fill
    input  wire logic [bertlv_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type, int_is_wide
    input  wire logic [bertlv_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  wire logic [bertlv_pkg::CLASS_W-1:0]   i_invalid_class,
    output logic                                o_push_valid,
    input  wire logic                           i_push_ready,
    output bertlv_pkg::t_job                    o_job
);
    import bertlv_pkg::*;

    // smallest byte count holding v, at least one
    function automatic logic [3:0] f_byte_count(input logic [INT_W-1:0] v);
        logic [3:0] n;
        n = 4'd1;
        for (int k = 1; k < 8; k++) begin
            if (v[8*k +: 8] != 8'd0) n = 4'(k + 1);
        end
        return n;
    endfunction

    logic [CLASS_W-1:0] cls;
    logic [TAG_W-1:0]   tag;
    logic [CLEN_W-1:0]  clen;
    logic [INT_W-1:0]   raw;
    logic [INT_W-1:0]   v;
    logic               req;
    logic               wide;
    logic [3:0]         len_octs;
    logic               len_top;
    logic               len_low;
    logic [3:0]         int_octs;
    logic [3:0]         int_width;
    logic               int_top;

    assign cls  = s_axis_tdata[CLASS_LSB +: CLASS_W];
    assign tag  = s_axis_tdata[TAG_LSB +: TAG_W];
    assign clen = s_axis_tdata[CLEN_LSB +: CLEN_W];
    assign raw  = s_axis_tdata[INT_LSB +: INT_W];
    assign req  = s_axis_tuser[TUSER_REQ];
    assign wide = s_axis_tuser[TUSER_WIDE];

    assign o_push_valid  = s_axis_tvalid;
    assign s_axis_tready = i_push_ready;

    // long-form length: octet count plus a leading zero above the half range
    always_comb begin
        len_octs = f_byte_count({{(INT_W-CLEN_W){1'b0}}, clen});
        len_top  = 1'b0;
        len_low  = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (len_octs == 4'(k + 1)) begin
                len_top = clen[8*k+7];
                len_low = (clen & ((32'd1 << (8*k+7)) - 32'd1)) != 32'd0;
            end
        end
        if (len_top && len_low) len_octs = len_octs + 4'd1;
    end

    // integer content size: full width when negative, minimal with sign guard otherwise
    always_comb begin
        v         = wide ? raw : {{(INT_W-32){raw[31]}}, raw[31:0]};
        int_width = wide ? 4'd8 : 4'd4;
        int_octs  = f_byte_count(v);
        int_top   = 1'b0;
        if (int_octs > 4'd7) int_octs = int_width;
        for (int k = 0; k < 8; k++) begin
            if (int_octs == 4'(k + 1)) int_top = v[8*k+7];
        end
        if (int_octs < int_width && int_top) int_octs = int_octs + 4'd1;
        if (v[INT_W-1]) int_octs = int_width;
    end

    // job assembly
    always_comb begin
        o_job     = '0;
        o_job.err = (cls == i_invalid_class);
        o_job.tag = tag;
        if (tag <= SHORT_TAG_MAX) begin
            o_job.hdr_byte = {cls, tag[4:0]};
            o_job.n_dig    = 3'd0;
        end else begin
            o_job.hdr_byte = {cls, HIGH_TAG_MARK};
            if (tag[31:7] == '0)       o_job.n_dig = 3'd1;
            else if (tag[31:14] == '0) o_job.n_dig = 3'd2;
            else if (tag[31:21] == '0) o_job.n_dig = 3'd3;
            else if (tag[31:28] == '0) o_job.n_dig = 3'd4;
            else                       o_job.n_dig = 3'd5;
        end
        if (req == REQ_INTEGER) begin
            o_job.len_byte = {4'd0, int_octs};
            o_job.n_body   = int_octs;
            o_job.body     = v;
        end else if (clen < SHORT_LEN_LIMIT) begin
            o_job.len_byte = clen[7:0];
            o_job.n_body   = 4'd0;
        end else begin
            o_job.len_byte = LONG_FORM | {4'd0, len_octs};
            o_job.n_body   = len_octs;
            o_job.body     = {{(INT_W-CLEN_W){1'b0}}, clen};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bertlv_queue.sv
// short job queue between front end and serializer
`default_nettype none

module bertlv_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_valid,
    output logic                   o_push_ready,
    input  wire bertlv_pkg::t_job  i_job,
    output logic                   o_pop_valid,
    input  wire logic              i_pop_ready,
    output bertlv_pkg::t_job       o_job
);
    import bertlv_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_job        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_job;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with fill level");

endmodule

`default_nettype wire

FILE: rtl/bertlv_back.sv
// back end: serializes one job into encoded bytes, one per cycle while the receiver accepts
`default_nettype none

module bertlv_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    output logic                                 o_q_ready,
    input  wire bertlv_pkg::t_job                i_q_job,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: out_byte
    output logic [bertlv_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast,
    // tuser: error
    output logic                                 m_axis_tuser
);
    import bertlv_pkg::*;

    typedef enum logic [1:0] {
        PH_ID,
        PH_DIG,
        PH_LEN,
        PH_BODY
    } t_phase;

    t_job       r_job;
    t_phase     r_phase;
    logic [2:0] r_idx;
    logic       r_busy;

    t_job       cur_job;
    t_phase     cur_ph;
    logic [2:0] cur_idx;
    t_phase     n_phase;
    logic [2:0] n_idx;
    logic [7:0] n_byte;
    logic       n_last;
    logic       n_err;
    logic       have;
    logic       adv;
    logic [7:0] digit;

    // work source: the job in progress, else the queue head at its first octet
    assign cur_job   = r_busy ? r_job : i_q_job;
    assign cur_ph    = r_busy ? r_phase : PH_ID;
    assign cur_idx   = r_busy ? r_idx : 3'd0;
    assign have      = r_busy || i_q_valid;
    assign adv       = !m_axis_tvalid || m_axis_tready;
    assign o_q_ready = !r_busy && adv;

    // base-128 digit selection
    always_comb begin
        case (cur_idx)
            3'd0:    digit = {1'b0, cur_job.tag[6:0]};
            3'd1:    digit = {1'b0, cur_job.tag[13:7]};
            3'd2:    digit = {1'b0, cur_job.tag[20:14]};
            3'd3:    digit = {1'b0, cur_job.tag[27:21]};
            default: digit = {4'd0, cur_job.tag[31:28]};
        endcase
        digit = digit & DIGIT_MASK;
        if (cur_idx != 3'd0) digit = digit | MORE_DIGITS;
    end

    // byte and next phase
    always_comb begin
        n_phase = cur_ph;
        n_idx   = cur_idx;
        n_byte  = 8'd0;
        n_last  = 1'b0;
        n_err   = 1'b0;
        case (cur_ph)
            PH_ID: begin
                if (cur_job.err) begin
                    n_last = 1'b1;
                    n_err  = 1'b1;
                end else begin
                    n_byte = cur_job.hdr_byte;
                    if (cur_job.n_dig != 3'd0) begin
                        n_phase = PH_DIG;
                        n_idx   = cur_job.n_dig - 3'd1;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
            end
            PH_DIG: begin
                n_byte = digit;
                if (cur_idx == 3'd0) n_phase = PH_LEN;
                else                 n_idx   = cur_idx - 3'd1;
            end
            PH_LEN: begin
                n_byte = cur_job.len_byte;
                if (cur_job.n_body == 4'd0) begin
                    n_last = 1'b1;
                end else begin
                    n_phase = PH_BODY;
                    n_idx   = 3'(cur_job.n_body - 4'd1);
                end
            end
            PH_BODY: begin
                n_byte = cur_job.body[{cur_idx, 3'b000} +: 8];
                if (cur_idx == 3'd0) n_last = 1'b1;
                else                 n_idx  = cur_idx - 3'd1;
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_phase       <= PH_ID;
            m_axis_tvalid <= 1'b0;
        end else if (adv) begin
            m_axis_tvalid <= have;
            if (have) begin
                m_axis_tdata <= n_byte;
                m_axis_tlast <= n_last;
                m_axis_tuser <= n_err;
                r_busy       <= !n_last;
                r_job        <= cur_job;
                r_phase      <= n_phase;
                r_idx        <= n_idx;
            end
        end
    end

    a_busy_past_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_phase != PH_ID))
        else $error("job in progress still at its first octet");

    a_body_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == PH_BODY) |-> ({1'b0, r_idx} < r_job.n_body))
        else $error("body byte index beyond body size");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && !r_busy))
        else $error("error result not alone");

endmodule

`default_nettype wire

FILE: rtl/ber_tlv_header_integer_encoder_unit.sv
// top level of the asn.1 ber header and integer element encoder
//
// Usage: each transaction on the s_axis side is one request. req_type 0
// emits identifier and length octets for content_length; req_type 1 emits
// a whole INTEGER element (identifier, length, two's complement content).
// The m_axis side carries one encoded byte per transaction, with tlast on
// the final byte of a request. A request whose class equals the configured
// invalid class yields a single transaction with tdata 0, tuser 1, tlast 1.
// With the serializer idle, a request passes through the job queue and
// the output register before its first byte is presented.
// Throughput: one byte per cycle while the receiver accepts; a request
// is 1 to 15 bytes long. A two-entry job queue decouples input and
// output, so input keeps flowing while the serializer works or the
// receiver stalls; once the queue is full, s_axis_tready drops until the
// serializer takes the next job. A receiver stall holds the current
// output byte. Reset empties the queue, drops tvalid and sets the invalid
// class to 7; configuration must be written by the user only while the
// block is idle, which the block itself does not enforce.
`default_nettype none

module ber_tlv_header_integer_encoder_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [bertlv_pkg::CLASS_W-1:0]   i_cfg_wr_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: ident_class, tag_number, content_length, int_value, zero fill
    input  wire logic [bertlv_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type, int_is_wide
    input  wire logic [bertlv_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: out_byte
    output logic [bertlv_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast,
    // tuser: error
    output logic                                  m_axis_tuser
);
    import bertlv_pkg::*;

    logic [CLASS_W-1:0] r_invalid_class;
    logic               push_valid;
    logic               push_ready;
    t_job               front_job;
    logic               q_valid;
    logic               q_ready;
    t_job               q_job;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_class <= 3'd7;
        end else if (i_cfg_wr_en) begin
            r_invalid_class <= i_cfg_wr_data;
        end
    end

    bertlv_front u_front (
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .i_invalid_class (r_invalid_class),
        .o_push_valid    (push_valid),
        .i_push_ready    (push_ready),
        .o_job           (front_job)
    );

    bertlv_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_job        (front_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_job        (q_job)
    );

    bertlv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_ready     (q_ready),
        .i_q_job       (q_job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
